// ===== hw/rtl/ura_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ura_pkg
// Shared constants, types and the digit-to-character mapping for the
// unsigned-to-radix ASCII converter.
// ---------------------------------------------------------------------------
package ura_pkg;

  // Default parameter values
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;

  // Quotient bits produced per division cycle
  localparam int STEP_BITS = 8;

  // Field widths
  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  // Radix register reset value and legal base range
  localparam logic [RADIX_W-1:0] RADIX_RST = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // Character codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A_LESS10 = 7'h37;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 4'd10;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_EMIT
  } ura_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div;
    logic wr;
    logic rd;
  } ura_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_step;
    logic quo_zero;
    logic digits_full;
    logic idx_zero;
  } ura_sts_t;

  // Digit value 0..15 to '0'-'9' / 'A'-'F'
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] base_char;
    base_char = (d < DIGIT_TEN) ? ASCII_ZERO : ASCII_A_LESS10;
    return base_char + CHAR_W'(d);
  endfunction

endpackage

// ===== hw/rtl/ura_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ura_ctrl
// Sequencer for the converter: load, per-digit division passes, digit
// write-back, then most-significant-first readout of the digit store.
// ---------------------------------------------------------------------------
module ura_ctrl
  import ura_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output ura_cmd_t cmd,
  input  ura_sts_t sts
);

  ura_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.last_step) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        if (sts.quo_zero || sts.digits_full) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_EMIT: begin
        cmd.rd = 1'b1;
        if (sts.idx_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Checks
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div, cmd.wr, cmd.rd}))
    else $error("ura_ctrl: more than one datapath command");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("ura_ctrl: accepted request did not raise busy");

  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(cmd.rd && sts.idx_zero))
    else $error("ura_ctrl: busy dropped before last digit read");

endmodule

// ===== hw/rtl/ura_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ura_dp
// Datapath: radix register, long division by the base STEP_BITS bits per
// cycle, digit store (least significant first) and registered readout.
// ---------------------------------------------------------------------------
module ura_dp
  import ura_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [RADIX_W-1:0]    cfg_wr_data,
  input  logic [VALUE_BITS-1:0] in_value,
  input  ura_cmd_t              cmd,
  output ura_sts_t              sts,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit
);

  localparam int STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int WORK_BITS = STEPS * STEP_BITS;
  localparam int SW        = $clog2(STEPS + 1);
  localparam int AW        = $clog2(MAX_DIGITS);

  logic [RADIX_W-1:0]   radix_r, radix_nxt;
  logic [RADIX_W-1:0]   base_r, base_nxt, base_sat;
  logic [WORK_BITS-1:0] n_r, n_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [SW-1:0]        step_cnt_r, step_cnt_nxt;
  logic [AW-1:0]        dig_cnt_r, dig_cnt_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic                 out_valid_r, out_last_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic [CHAR_W-1:0]    mem [MAX_DIGITS];

  logic [STEP_BITS-1:0] chunk, q_bits;
  logic [DIGIT_W-1:0]   r_div;
  logic [RADIX_W-1:0]   t_div;

  // Radix register
  always_comb begin
    radix_nxt = cfg_wr_en ? cfg_wr_data : radix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RST;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  // Clamp base to 2..16
  always_comb begin
    if (radix_r < RADIX_MIN) begin
      base_sat = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base_sat = RADIX_MAX;
    end else begin
      base_sat = radix_r;
    end
  end

  // One division cycle: restoring steps over the top chunk of the dividend
  always_comb begin
    chunk  = n_r[WORK_BITS-1 -: STEP_BITS];
    r_div  = rem_r;
    q_bits = '0;
    t_div  = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t_div = {r_div, chunk[i]};
      if (t_div >= base_r) begin
        q_bits[i] = 1'b1;
        r_div     = DIGIT_W'(t_div - base_r);
      end else begin
        r_div     = t_div[DIGIT_W-1:0];
      end
    end
  end

  // Next-state for working registers
  always_comb begin
    base_nxt     = base_r;
    n_nxt        = n_r;
    rem_nxt      = rem_r;
    step_cnt_nxt = step_cnt_r;
    dig_cnt_nxt  = dig_cnt_r;
    idx_nxt      = idx_r;
    if (cmd.load) begin
      base_nxt     = base_sat;
      n_nxt        = WORK_BITS'(in_value);
      rem_nxt      = '0;
      step_cnt_nxt = '0;
      dig_cnt_nxt  = '0;
    end
    if (cmd.div) begin
      // quotient bits rotate in at the bottom as dividend bits leave the top
      n_nxt        = (n_r << STEP_BITS) | WORK_BITS'(q_bits);
      rem_nxt      = r_div;
      step_cnt_nxt = step_cnt_r + SW'(1);
    end
    if (cmd.wr) begin
      rem_nxt      = '0;
      step_cnt_nxt = '0;
      dig_cnt_nxt  = dig_cnt_r + AW'(1);
      idx_nxt      = dig_cnt_r;
    end
    if (cmd.rd) begin
      idx_nxt = idx_r - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cnt_r <= '0;
      dig_cnt_r  <= '0;
      idx_r      <= '0;
    end else begin
      step_cnt_r <= step_cnt_nxt;
      dig_cnt_r  <= dig_cnt_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
  end

  // Digit store: write at digit count, read at readout index
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[dig_cnt_r] <= digit_glyph(rem_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      out_char_r <= mem[idx_r];
    end
  end

  // Result strobe is asserted in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.rd;
      out_last_r  <= cmd.rd && (idx_r == '0);
    end
  end

  // Status
  always_comb begin
    sts.last_step   = (step_cnt_r == SW'(STEPS - 1));
    sts.quo_zero    = (n_r == '0);
    sts.digits_full = (dig_cnt_r == AW'(MAX_DIGITS - 1));
    sts.idx_zero    = (idx_r == '0);
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

  // Checks
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (base_r >= RADIX_MIN && base_r <= RADIX_MAX))
    else $error("ura_dp: division base out of range");

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> ({1'b0, rem_r} < base_r))
    else $error("ura_dp: remainder not below base at digit write");

  a_last_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_digit |-> out_valid)
    else $error("ura_dp: last-digit flag without strobe");

endmodule

// ===== hw/rtl/unsigned_to_radix_ascii.sv =====
`timescale 1ns / 1ps
// Operation: a load, then per digit the division passes (8 quotient bits per
//   cycle) and one digit write, then the digits are read out one per cycle;
//   the first result comes in the cycle after the first read.
// A new value is taken only when idle, after the last digit has been read out.
// Reset (synchronous, rst_n low): idle, radix = 10; results cannot be stalled.
// ---------------------------------------------------------------------------
// unsigned_to_radix_ascii
// Converts an unsigned value to ASCII digits in base 2..16, one character
// per strobe, most significant first, last digit flagged.
// ---------------------------------------------------------------------------
module unsigned_to_radix_ascii
  import ura_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [RADIX_W-1:0]    cfg_wr_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit
);

  ura_cmd_t cmd;
  ura_sts_t sts;

  // Sequencer
  ura_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Divider, digit store and readout
  ura_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule
